// ===== rtl/core/mcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared codes, constants and the queue entry type of the motor command
// byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbd_pkg;

   // parser phases
   localparam logic [2:0] PH_SYNC = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_FB1  = 3'd2;
   localparam logic [2:0] PH_FB2  = 3'd3;
   localparam logic [2:0] PH_P    = 3'd4;

   // protocol characters
   localparam logic [7:0] CH_SYNC  = 8'h30; // '0'
   localparam logic [7:0] CH_FWD   = 8'h46; // 'F'
   localparam logic [7:0] CH_BACK  = 8'h42; // 'B'
   localparam logic [7:0] CH_W     = 8'h77; // 'w'
   localparam logic [7:0] CH_S     = 8'h73; // 's'
   localparam logic [7:0] CH_A     = 8'h61; // 'a'
   localparam logic [7:0] CH_D     = 8'h64; // 'd'
   localparam logic [7:0] CH_B     = 8'h62; // 'b'
   localparam logic [7:0] CH_P     = 8'h70; // 'p'
   localparam logic [7:0] CH_ACK   = 8'h44; // 'D'

   // direction pin patterns
   localparam logic [3:0] PINS_FWD   = 4'd5;
   localparam logic [3:0] PINS_LEFT  = 4'd6;
   localparam logic [3:0] PINS_RIGHT = 4'd9;
   localparam logic [3:0] PINS_BACK  = 4'd10;
   localparam logic [3:0] PINS_STOP  = 4'd0;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one command that makes results: an acknowledge alone, or two echoes
   // followed by an acknowledge
   typedef struct packed {
      logic       triple;
      logic [3:0] pins;
      logic [7:0] old_left;
      logic [7:0] old_right;
      logic [7:0] new_left;
      logic [7:0] new_right;
      logic [7:0] echo_a;
      logic [7:0] echo_b;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/mcbd_front.sv =====
// ----------------------------------------------------------------------------
// mcbd_front
// Byte parser: tracks sync, command and duty phases, holds motor state and
// pushes one command entry for every byte that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   byte_valid,
   input  wire  [7:0]            byte_data,
   output mcbd_pkg::cmd_type     push_cmd,
   output logic                  push_valid
);

   logic [2:0] phase_ff,   phase_in;
   logic       go_back_ff, go_back_in;
   logic [7:0] held_ff,    held_in;
   logic [3:0] pins_ff,    pins_in;
   logic [7:0] left_ff,    left_in;
   logic [7:0] right_ff,   right_in;

   always_comb begin
      phase_in   = phase_ff;
      go_back_in = go_back_ff;
      held_in    = held_ff;
      pins_in    = pins_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      push_valid = 1'b0;
      push_cmd   = '0;

      case (phase_ff)
         mcbd_pkg::PH_CMD: begin
            case (byte_data)
               mcbd_pkg::CH_FWD: begin
                  go_back_in = 1'b0;
                  phase_in   = mcbd_pkg::PH_FB1;
               end
               mcbd_pkg::CH_BACK: begin
                  go_back_in = 1'b1;
                  phase_in   = mcbd_pkg::PH_FB1;
               end
               mcbd_pkg::CH_P: phase_in = mcbd_pkg::PH_P;
               mcbd_pkg::CH_W: begin
                  pins_in    = mcbd_pkg::PINS_FWD;
                  push_valid = 1'b1;
               end
               mcbd_pkg::CH_S: begin
                  pins_in    = mcbd_pkg::PINS_STOP;
                  push_valid = 1'b1;
               end
               mcbd_pkg::CH_A: begin
                  pins_in    = mcbd_pkg::PINS_LEFT;
                  push_valid = 1'b1;
               end
               mcbd_pkg::CH_D: begin
                  pins_in    = mcbd_pkg::PINS_RIGHT;
                  push_valid = 1'b1;
               end
               mcbd_pkg::CH_B: begin
                  pins_in    = mcbd_pkg::PINS_BACK;
                  push_valid = 1'b1;
               end
               default: ;
            endcase
         end
         mcbd_pkg::PH_FB1: begin
            held_in  = byte_data;
            phase_in = mcbd_pkg::PH_FB2;
         end
         mcbd_pkg::PH_FB2: begin
            pins_in         = go_back_ff ? mcbd_pkg::PINS_BACK : mcbd_pkg::PINS_FWD;
            left_in         = held_ff;
            right_in        = byte_data;
            push_valid      = 1'b1;
            push_cmd.triple = 1'b1;
            push_cmd.echo_a = held_ff;
            push_cmd.echo_b = byte_data;
            phase_in        = mcbd_pkg::PH_SYNC;
         end
         mcbd_pkg::PH_P: begin
            left_in         = byte_data;
            right_in        = byte_data;
            push_valid      = 1'b1;
            push_cmd.triple = 1'b1;
            push_cmd.echo_a = byte_data;
            push_cmd.echo_b = byte_data;
            phase_in        = mcbd_pkg::PH_SYNC;
         end
         default: begin
            phase_in = (byte_data == mcbd_pkg::CH_SYNC) ? mcbd_pkg::PH_CMD
                                                        : mcbd_pkg::PH_SYNC;
         end
      endcase

      push_cmd.pins      = pins_in;
      push_cmd.old_left  = left_ff;
      push_cmd.old_right = right_ff;
      push_cmd.new_left  = left_in;
      push_cmd.new_right = right_in;
      push_valid         = push_valid & byte_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mcbd_pkg::PH_SYNC;
         go_back_ff <= 1'b0;
         held_ff    <= 8'd0;
         pins_ff    <= mcbd_pkg::PINS_STOP;
         left_ff    <= 8'd0;
         right_ff   <= 8'd0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         go_back_ff <= go_back_in;
         held_ff    <= held_in;
         pins_ff    <= pins_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcbd_queue.sv =====
// ----------------------------------------------------------------------------
// mcbd_queue
// Two-entry queue of command entries between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbd_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire mcbd_pkg::cmd_type push_cmd,
   output logic                  not_full,
   input  wire                   pop,
   output mcbd_pkg::cmd_type     head_cmd,
   output logic                  not_empty
);

   mcbd_pkg::cmd_type                 mem_ff [mcbd_pkg::QDEPTH];
   logic [mcbd_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [mcbd_pkg::QCNT_W-1:0]       count_ff,  count_in;

   assign not_full  = (count_ff != mcbd_pkg::QCNT_W'(mcbd_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcbd_back.sv =====
// ----------------------------------------------------------------------------
// mcbd_back
// Result emitter: expands each queued command into one or three results and
// holds them in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire mcbd_pkg::cmd_type head_cmd,
   input  wire                   head_valid,
   output logic                  pop,
   output logic                  out_valid,
   input  wire                   out_ready,
   output logic [7:0]            out_byte,
   output logic [3:0]            out_pins,
   output logic [7:0]            out_left,
   output logic [7:0]            out_right,
   output logic                  out_last
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff,  byte_in;
   logic [3:0] pins_ff;
   logic [7:0] left_ff,  left_in;
   logic [7:0] right_ff, right_in;
   logic       last_ff,  last_in;
   logic       load;

   assign load = head_valid && (!valid_ff || out_ready);

   always_comb begin
      last_in  = !head_cmd.triple || (idx_ff == 2'd2);
      byte_in  = mcbd_pkg::CH_ACK;
      left_in  = head_cmd.new_left;
      right_in = head_cmd.new_right;
      if (!last_in) begin
         byte_in  = (idx_ff == 2'd0) ? head_cmd.echo_a : head_cmd.echo_b;
         left_in  = head_cmd.old_left;
         right_in = head_cmd.old_right;
      end
      pop = load && last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last_in ? 2'd0 : idx_ff + 2'd1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         pins_ff  <= head_cmd.pins;
         left_ff  <= left_in;
         right_ff <= right_in;
         last_ff  <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_pins  = pins_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/motor_command_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// motor_command_byte_decoder_top
// Serial command decoder for a two-motor drive.
//
// Bytes from the serial receiver enter on the req_ channel, one per transfer.
// The block waits for the sync byte '0', then decodes a command byte. Drive
// commands (w s a d b) give one 'D' acknowledge; 'F'/'B' take two duty bytes
// and 'p' takes one, and each of those gives two echoes followed by 'D'.
// Every result on the rsp_ channel carries the byte to send, the direction
// pins and both duties; rsp_last marks the final result of an input byte.
// Bytes that cause nothing produce no rsp_ transfer.
// Each result is held in the back end's output register, which loads only
// when empty or being taken. A byte is taken every cycle while the
// two-entry command queue has room; the emitter drains one result per
// cycle while rsp_ready is high: three for a duty command, one for others.
// Reset clears the parser to wait-for-sync, pins low and duties zero, and
// empties the queue and output register. When the receiver stalls, the
// output register holds; the queue absorbs up to two more commands and then
// req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_command_byte_decoder_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [3:0]  rsp_direction_pins,
   output logic [7:0]  rsp_left_duty,
   output logic [7:0]  rsp_right_duty,
   output logic        rsp_last
);

   mcbd_pkg::cmd_type push_cmd;
   mcbd_pkg::cmd_type head_cmd;
   logic              push_valid;
   logic              q_not_full;
   logic              q_not_empty;
   logic              pop;
   logic              req_fire;

   // accept a byte whenever the queue can take whatever it may push
   assign req_ready = q_not_full;
   assign req_fire  = req_valid && q_not_full;

   mcbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_fire),
      .byte_data  (req_rx_byte),
      .push_cmd   (push_cmd),
      .push_valid (push_valid)
   );

   mcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_cmd  (push_cmd),
      .not_full  (q_not_full),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty)
   );

   mcbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (q_not_empty),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_byte   (rsp_tx_byte),
      .out_pins   (rsp_direction_pins),
      .out_left   (rsp_left_duty),
      .out_right  (rsp_right_duty),
      .out_last   (rsp_last)
   );

   // every result is a byte to send
   assign rsp_tx_valid = 1'b1;

endmodule

`default_nettype wire

// ===== verif/mcbd_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_result_checker
// Watches both channels of the motor command byte decoder. Every accepted
// byte runs through a local copy of the parser, which queues the results
// due. Every result transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module mcbd_result_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire  [7:0] req_rx_byte,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire        rsp_tx_valid,
   input  wire  [7:0] rsp_tx_byte,
   input  wire  [3:0] rsp_direction_pins,
   input  wire  [7:0] rsp_left_duty,
   input  wire  [7:0] rsp_right_duty,
   input  wire        rsp_last,
   output int         mismatch_count,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [3:0] pins;
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic       last;
   } drive_answer_type;

   drive_answer_type due_answers[$];

   // parser state mirror
   logic [2:0] phase;
   logic       backward;
   logic [7:0] first_duty;
   logic [3:0] pins;
   logic [7:0] left_cmp;
   logic [7:0] right_cmp;

   task automatic queue_answer(input logic [7:0] b);
      drive_answer_type a;
      a.tx_byte    = b;
      a.pins       = pins;
      a.left_duty  = left_cmp;
      a.right_duty = right_cmp;
      a.last       = 1'b0;
      due_answers.push_back(a);
   endtask

   task automatic decode_byte(input logic [7:0] b);
      int               start_size;
      drive_answer_type tail;
      start_size = due_answers.size();
      case (phase)
         mcbd_pkg::PH_CMD: begin
            case (b)
               mcbd_pkg::CH_FWD: begin
                  backward = 1'b0;
                  phase    = mcbd_pkg::PH_FB1;
               end
               mcbd_pkg::CH_BACK: begin
                  backward = 1'b1;
                  phase    = mcbd_pkg::PH_FB1;
               end
               mcbd_pkg::CH_P: phase = mcbd_pkg::PH_P;
               mcbd_pkg::CH_W: begin
                  pins = mcbd_pkg::PINS_FWD;
                  queue_answer(mcbd_pkg::CH_ACK);
               end
               mcbd_pkg::CH_S: begin
                  pins = mcbd_pkg::PINS_STOP;
                  queue_answer(mcbd_pkg::CH_ACK);
               end
               mcbd_pkg::CH_A: begin
                  pins = mcbd_pkg::PINS_LEFT;
                  queue_answer(mcbd_pkg::CH_ACK);
               end
               mcbd_pkg::CH_D: begin
                  pins = mcbd_pkg::PINS_RIGHT;
                  queue_answer(mcbd_pkg::CH_ACK);
               end
               mcbd_pkg::CH_B: begin
                  pins = mcbd_pkg::PINS_BACK;
                  queue_answer(mcbd_pkg::CH_ACK);
               end
               default: ;
            endcase
         end
         mcbd_pkg::PH_FB1: begin
            first_duty = b;
            phase      = mcbd_pkg::PH_FB2;
         end
         mcbd_pkg::PH_FB2: begin
            // direction first, duties only after both echoes
            pins = backward ? mcbd_pkg::PINS_BACK : mcbd_pkg::PINS_FWD;
            queue_answer(first_duty);
            queue_answer(b);
            left_cmp  = first_duty;
            right_cmp = b;
            queue_answer(mcbd_pkg::CH_ACK);
            phase = mcbd_pkg::PH_SYNC;
         end
         mcbd_pkg::PH_P: begin
            queue_answer(b);
            queue_answer(b);
            left_cmp  = b;
            right_cmp = b;
            queue_answer(mcbd_pkg::CH_ACK);
            phase = mcbd_pkg::PH_SYNC;
         end
         default: phase = (b == mcbd_pkg::CH_SYNC) ? mcbd_pkg::PH_CMD : mcbd_pkg::PH_SYNC;
      endcase
      // mark the final result of this byte
      if (due_answers.size() > start_size) begin
         tail      = due_answers.pop_back();
         tail.last = 1'b1;
         due_answers.push_back(tail);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got, inout int bad);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         bad++;
      end
   endtask

   always @(posedge clock) begin
      drive_answer_type want;
      int               bad;
      bad = 0;
      if (reset) begin
         phase      = mcbd_pkg::PH_SYNC;
         backward   = 1'b0;
         first_duty = 8'd0;
         pins       = mcbd_pkg::PINS_STOP;
         left_cmp   = 8'd0;
         right_cmp  = 8'd0;
         due_answers.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               $error("unexpected result transfer, tx_byte 0x%0h", rsp_tx_byte);
               bad++;
            end else begin
               want = due_answers.pop_front();
               check_field("tx_valid", 32'd1, 32'(rsp_tx_valid), bad);
               check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte), bad);
               check_field("direction_pins", 32'(want.pins), 32'(rsp_direction_pins),
                           bad);
               check_field("left_duty", 32'(want.left_duty), 32'(rsp_left_duty), bad);
               check_field("right_duty", 32'(want.right_duty), 32'(rsp_right_duty),
                           bad);
               check_field("last", 32'(want.last), 32'(rsp_last), bad);
            end
         end
      end
      mismatch_count <= mismatch_count + bad;
      outstanding    <= due_answers.size();
   end

endmodule

// ===== verif/tb_motor_command_byte_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_command_byte_decoder_top
// Drives serial command bytes into the motor command decoder with random
// sender gaps and receiver stalls; the checker beside the block predicts
// and compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------

module tb_motor_command_byte_decoder_top;

   // cycles without any transfer before the run is declared hung
   localparam int HANG_LIMIT = 2000;
   // receiver hold-off used to fill the command queue
   localparam int LONG_HOLD  = 90;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_ready   = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire        rsp_tx_valid;
   wire  [7:0] rsp_tx_byte;
   wire  [3:0] rsp_direction_pins;
   wire  [7:0] rsp_left_duty;
   wire  [7:0] rsp_right_duty;
   wire        rsp_last;
   int         mismatch_count;
   int         outstanding;

   // stimulus bookkeeping
   int         sent_items    = 0;   // every byte transferred so far
   int         quiet_items   = 0;   // bytes left to send back to back
   int         hold_request  = 0;   // bumped to ask for a long receiver stall

   motor_command_byte_decoder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_direction_pins (rsp_direction_pins),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_last           (rsp_last)
   );

   mcbd_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_direction_pins (rsp_direction_pins),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_last           (rsp_last),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hold reset at the start of the run, then release it once
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender gap: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Receiver stall: mostly short, a few long.
   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   // Duty bytes lean toward the extremes now and then.
   function automatic logic [7:0] pick_duty();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one byte, hold it until the transfer, then maybe drop valid for a
   // gap. Valid is not dropped when the next byte follows straight away.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      if (quiet_items > 0) begin
         quiet_items--;
         gap = 0;
      end else begin
         // now and then start a stretch with no gaps at all
         if ($urandom_range(0, 19) == 0) quiet_items = $urandom_range(10, 40);
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Duty command after sync: F or B with two duties, or p with one.
   task automatic send_duty_body();
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 2) begin
         send_byte(mcbd_pkg::CH_P);
         send_byte(pick_duty());
      end else begin
         send_byte(pick == 0 ? mcbd_pkg::CH_FWD : mcbd_pkg::CH_BACK);
         send_byte(pick_duty());
         send_byte(pick_duty());
      end
   endtask

   // Sync, then a run of drive commands, possibly with an unknown byte mixed
   // in, and sometimes closed by a duty command without a fresh sync.
   task automatic send_drive_run();
      logic [7:0] drive_codes [5];
      int         n;
      drive_codes = '{mcbd_pkg::CH_W, mcbd_pkg::CH_S, mcbd_pkg::CH_A,
                      mcbd_pkg::CH_D, mcbd_pkg::CH_B};
      send_byte(mcbd_pkg::CH_SYNC);
      n = $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
         else send_byte(drive_codes[$urandom_range(0, 4)]);
      end
      if ($urandom_range(0, 9) < 3) send_duty_body();
   endtask

   // Random bytes: mostly ignored, sometimes a broken sequence.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Ask the receiver for a long hold-off and keep offering duty commands
   // back to back so that the queue fills and req_ready drops.
   task automatic fill_while_held();
      hold_request <= hold_request + 1;
      quiet_items = 40;
      repeat (8) begin
         send_byte(mcbd_pkg::CH_SYNC);
         send_duty_body();
      end
   endtask

   // Stimulus and verdict
   initial begin
      logic [7:0] opening [24];
      bit         first_fill;
      bit         second_fill;
      int         pick;
      first_fill  = 1'b0;
      second_fill = 1'b0;
      // stray byte before sync, every drive command, a second sync inside
      // command mode, F and B with duty extremes, p, p while waiting for
      // sync, an unknown command, and a stray byte after a duty command
      opening = '{8'h78, mcbd_pkg::CH_SYNC, mcbd_pkg::CH_W, mcbd_pkg::CH_A,
                  mcbd_pkg::CH_D, mcbd_pkg::CH_B, mcbd_pkg::CH_S, mcbd_pkg::CH_SYNC,
                  mcbd_pkg::CH_FWD, 8'h00, 8'hFF,
                  mcbd_pkg::CH_SYNC, mcbd_pkg::CH_BACK, 8'hFF, 8'h00,
                  mcbd_pkg::CH_SYNC, mcbd_pkg::CH_P, 8'hA5,
                  mcbd_pkg::CH_P, mcbd_pkg::CH_SYNC, 8'h71, mcbd_pkg::CH_P,
                  8'h5A, 8'hFF};
      while (reset) @(posedge clock);
      foreach (opening[i]) send_byte(opening[i]);

      // random part: well-formed sequences with random content, plus noise
      while (sent_items < 380) begin
         if (!first_fill && sent_items >= 100) begin
            first_fill = 1'b1;
            fill_while_held();
         end else if (!second_fill && sent_items >= 260) begin
            second_fill = 1'b1;
            fill_while_held();
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_byte(mcbd_pkg::CH_SYNC);
            send_duty_body();
         end else if (pick < 80) begin
            send_drive_run();
         end else begin
            send_noise();
         end
      end
      req_valid <= 1'b0;

      // drain: wait for every due result, then let the pipeline settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: random stalls, calm stretches, and long hold-offs on request.
   initial begin
      int stall_left;
      int hold_served;
      bit calm;
      stall_left  = 0;
      hold_served = 0;
      calm        = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != hold_served) begin
            hold_served = hold_request;
            stall_left  = LONG_HOLD;
         end
         if ($urandom_range(0, 63) == 0) calm = !calm;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_stall();
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

endmodule
